FILE: design/dhmt_pkg.sv
package dhmt_pkg;

  localparam int TABLE_SLOTS_DEF = 1021;
  localparam int ELEM_W          = 32;
  localparam int OPC_W           = 2;
  localparam int OCC_W           = 10;
  localparam int OUT_W           = 24;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

FILE: design/dhmt_ram.sv
module dhmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/dhmt_hash.sv
// Probe hash: |e| mod N and |e| mod (N-1) side by side, by reciprocal
// multiplication. For a divisor d, q = floor(a * floor(2^S / d) / 2^S) with
// S = 32 + clog2(d) is at most one below a / d, so a - q * d lies in [0, 2d)
// and one compare and subtract finishes it. Four register stages; done rises with the
// registered remainders, start passing through v1_r, v2_r and v3_r to done_r.
module dhmt_hash #(
  parameter int TABLE_SLOTS = dhmt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dhmt_pkg::ELEM_W-1:0]    element,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] pos,
  output logic [$clog2(TABLE_SLOTS)-1:0] stride
);

  localparam int EW   = dhmt_pkg::ELEM_W;
  localparam int IW   = $clog2(TABLE_SLOTS);
  localparam int JW   = $clog2(TABLE_SLOTS - 1);
  localparam int SH_A = EW + IW;
  localparam int SH_B = EW + JW;
  localparam int RCW  = EW + 1;              // reciprocal width
  localparam int PW   = EW + RCW;            // product width
  localparam int QA   = PW - SH_A;
  localparam int QB   = PW - SH_B;
  localparam logic [RCW-1:0] RCP_A = RCW'((64'd1 << SH_A) / 64'(TABLE_SLOTS));
  localparam logic [RCW-1:0] RCP_B = RCW'((64'd1 << SH_B) / 64'(TABLE_SLOTS - 1));
  localparam logic [EW-1:0]  DIV_A = EW'(TABLE_SLOTS);
  localparam logic [EW-1:0]  DIV_B = EW'(TABLE_SLOTS - 1);
  localparam logic [IW:0]    MOD_A = (IW+1)'(TABLE_SLOTS);
  localparam logic [JW:0]    MOD_B = (JW+1)'(TABLE_SLOTS - 1);

  logic            v1_r, v2_r, v3_r, done_r;
  logic [EW-1:0]   mag_r, mag_nxt;
  logic [PW-1:0]   prod_a, prod_b;
  logic [QA-1:0]   quo_a_r, quo_a_nxt;
  logic [QB-1:0]   quo_b_r, quo_b_nxt;
  logic [EW-1:0]   diff_a, diff_b;
  logic [IW:0]     part_a_r, part_a_nxt;
  logic [JW:0]     part_b_r, part_b_nxt;
  logic [IW-1:0]   rem_a_r, rem_a_nxt;
  logic [JW-1:0]   rem_b_r, rem_b_nxt;

  // magnitude as unsigned; the most negative value maps to 2^31
  assign mag_nxt    = element[EW-1] ? (~element + 1'b1) : element;

  // quotient estimate, low by at most one
  assign prod_a     = PW'(mag_r) * PW'(RCP_A);
  assign prod_b     = PW'(mag_r) * PW'(RCP_B);
  assign quo_a_nxt  = prod_a[PW-1:SH_A];
  assign quo_b_nxt  = prod_b[PW-1:SH_B];

  // partial remainder below 2d
  assign diff_a     = mag_r - EW'(quo_a_r) * DIV_A;
  assign diff_b     = mag_r - EW'(quo_b_r) * DIV_B;
  assign part_a_nxt = diff_a[IW:0];
  assign part_b_nxt = diff_b[JW:0];

  assign rem_a_nxt  = (part_a_r >= MOD_A) ? IW'(part_a_r - MOD_A) : part_a_r[IW-1:0];
  assign rem_b_nxt  = (part_b_r >= MOD_B) ? JW'(part_b_r - MOD_B) : part_b_r[JW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
    if (start) begin
      mag_r <= mag_nxt;
    end
    quo_a_r  <= quo_a_nxt;
    quo_b_r  <= quo_b_nxt;
    part_a_r <= part_a_nxt;
    part_b_r <= part_b_nxt;
    rem_a_r  <= rem_a_nxt;
    rem_b_r  <= rem_b_nxt;
  end

  assign done   = done_r;
  assign pos    = rem_a_r;
  assign stride = IW'(rem_b_r) + IW'(1);

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_a_r} < MOD_A) && ({1'b0, rem_b_r} < MOD_B))
    else $error("remainder not reduced");

  a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ({1'b0, part_a_r} < {MOD_A, 1'b0}) && ({1'b0, part_b_r} < {MOD_B, 1'b0}))
    else $error("quotient estimate off by more than one");

  a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 done_r)
    else $error("missing done after start");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held past one cycle");

endmodule

FILE: design/double_hash_multiset_table.sv
// Channel  Dir  Ports                          Contents
// in       in   in_tvalid/in_tready            in_tuser: opcode; in_tdata: element
// out      out  out_tvalid/out_tready          out_tdata: result flags, counts
//
// Each transfer: the probe hash (pipelined reciprocal remainder), then one slot
// read per probe on the single table RAM read port, each checked once its registered
// read returns, then the hand-off. Search, count, a missed remove and a refused insert
// take TABLE_SLOTS probes; an insert or remove that hits stops at that probe.
// After reset the table RAM is swept clear, slot by slot, with in_tready low.
// The next item is taken while a result still waits in the output register; an item
// stalls in its last state only if out is busy.
module double_hash_multiset_table #(
  parameter int TABLE_SLOTS = dhmt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dhmt_pkg::ELEM_W-1:0]   in_tdata,   // [31:0] element
  input  logic [dhmt_pkg::OPC_W-1:0]    in_tuser,   // [1:0] opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] success, [1] table_full, [11:2] occurrences, [21:12] bag_size,
  // [22] bag_empty, [23] zero
  output logic [dhmt_pkg::OUT_W-1:0]    out_tdata
);

  localparam int IW  = $clog2(TABLE_SLOTS);
  localparam int CW  = $clog2(TABLE_SLOTS + 1);
  localparam int EW  = dhmt_pkg::ELEM_W;
  localparam int RW  = EW + 1;             // valid bit on top of the value
  localparam logic [IW:0] SLOTS_X = (IW+1)'(TABLE_SLOTS);

  dhmt_pkg::state_t state_r, state_nxt;
  dhmt_pkg::op_t    op_r, op_nxt;
  logic [EW-1:0]    elem_r, elem_nxt;
  logic [IW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [IW-1:0]    iss_pos_r, iss_pos_nxt;
  logic [IW-1:0]    stride_r, stride_nxt;
  logic [CW-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic             ev_vld_r, ev_vld_nxt;
  logic             ev_last_r, ev_last_nxt;
  logic [IW-1:0]    ev_pos_r, ev_pos_nxt;
  logic [CW-1:0]    occ_r, occ_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             succ_r, succ_nxt;
  logic             full_r, full_nxt;
  logic             out_tvalid_r;
  logic [dhmt_pkg::OUT_W-1:0] out_tdata_r;

  logic             hash_start, hash_done;
  logic [IW-1:0]    hash_pos, hash_stride;
  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr;
  logic [RW-1:0]    ram_wdata, ram_rdata;
  logic             slot_vld, slot_hit, issue, out_load;
  logic [IW:0]      pos_sum;
  logic [IW-1:0]    pos_next;

  dhmt_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .element (elem_nxt),
    .done    (hash_done),
    .pos     (hash_pos),
    .stride  (hash_stride)
  );

  dhmt_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (iss_pos_r),
    .rd_data (ram_rdata)
  );

  // probe slot returned by the read issued in the previous cycle
  assign slot_vld = ram_rdata[EW];
  assign slot_hit = slot_vld && (ram_rdata[EW-1:0] == elem_r);

  // next probe: pos + stride stays below 2N, one conditional subtract
  assign pos_sum  = {1'b0, iss_pos_r} + {1'b0, stride_r};
  assign pos_next = (pos_sum >= SLOTS_X) ? IW'(pos_sum - SLOTS_X) : IW'(pos_sum);
  assign issue    = (iss_cnt_r != CW'(TABLE_SLOTS));
  assign out_load = (state_r == dhmt_pkg::S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    elem_nxt     = elem_r;
    clr_addr_nxt = clr_addr_r;
    iss_pos_nxt  = iss_pos_r;
    stride_nxt   = stride_r;
    iss_cnt_nxt  = iss_cnt_r;
    ev_vld_nxt   = 1'b0;
    ev_last_nxt  = ev_last_r;
    ev_pos_nxt   = ev_pos_r;
    occ_nxt      = occ_r;
    count_nxt    = count_r;
    succ_nxt     = succ_r;
    full_nxt     = full_r;
    in_tready    = 1'b0;
    hash_start   = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = ev_pos_r;
    ram_wdata    = {1'b0, elem_r};
    unique case (state_r)
      dhmt_pkg::S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IW'(TABLE_SLOTS - 1)) begin
          state_nxt = dhmt_pkg::S_IDLE;
        end
      end
      dhmt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt     = dhmt_pkg::op_t'(in_tuser);
          elem_nxt   = in_tdata;
          hash_start = 1'b1;
          state_nxt  = dhmt_pkg::S_HASH;
        end
      end
      dhmt_pkg::S_HASH: begin
        if (hash_done) begin
          iss_pos_nxt = hash_pos;
          stride_nxt  = hash_stride;
          iss_cnt_nxt = '0;
          occ_nxt     = '0;
          succ_nxt    = 1'b0;
          full_nxt    = 1'b0;
          state_nxt   = dhmt_pkg::S_PROBE;
        end
      end
      dhmt_pkg::S_PROBE: begin
        // issue side: one read per cycle along the probe sequence; no write
        // happens until the walk ends, so reads in flight never see a stale slot
        if (issue) begin
          ram_re      = 1'b1;
          iss_pos_nxt = pos_next;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          ev_vld_nxt  = 1'b1;
          ev_pos_nxt  = iss_pos_r;
          ev_last_nxt = (iss_cnt_r == CW'(TABLE_SLOTS - 1));
        end
        // evaluate side
        if (ev_vld_r) begin
          unique case (op_r)
            dhmt_pkg::OP_INSERT: begin
              if (!slot_vld) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, elem_r};
                count_nxt = count_r + 1'b1;
                succ_nxt  = 1'b1;
                state_nxt = dhmt_pkg::S_DONE;
              end else if (ev_last_r) begin
                full_nxt  = 1'b1;
                state_nxt = dhmt_pkg::S_DONE;
              end
            end
            dhmt_pkg::OP_REMOVE: begin
              if (slot_hit) begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                count_nxt = count_r - 1'b1;
                succ_nxt  = 1'b1;
                state_nxt = dhmt_pkg::S_DONE;
              end else if (ev_last_r) begin
                state_nxt = dhmt_pkg::S_DONE;
              end
            end
            dhmt_pkg::OP_SEARCH, dhmt_pkg::OP_COUNT: begin
              occ_nxt = occ_r + CW'(slot_hit);
              if (ev_last_r) begin
                succ_nxt  = (occ_nxt != '0);
                state_nxt = dhmt_pkg::S_DONE;
              end
            end
          endcase
        end
        if (state_nxt == dhmt_pkg::S_DONE) begin
          ev_vld_nxt = 1'b0;
        end
      end
      dhmt_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = dhmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dhmt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dhmt_pkg::S_CLEAR;
      clr_addr_r <= '0;
      iss_cnt_r  <= '0;
      ev_vld_r   <= 1'b0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      iss_cnt_r  <= iss_cnt_nxt;
      ev_vld_r   <= ev_vld_nxt;
      count_r    <= count_nxt;
    end
    op_r      <= op_nxt;
    elem_r    <= elem_nxt;
    iss_pos_r <= iss_pos_nxt;
    stride_r  <= stride_nxt;
    ev_last_r <= ev_last_nxt;
    ev_pos_r  <= ev_pos_nxt;
    occ_r     <= occ_nxt;
    succ_r    <= succ_nxt;
    full_r    <= full_nxt;
  end

  // output register; refilled in the cycle the old result transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (out_load) begin
      out_tdata_r <= {1'b0,
                      (count_r == '0),
                      dhmt_pkg::OCC_W'(count_r),
                      (op_r == dhmt_pkg::OP_COUNT) ? dhmt_pkg::OCC_W'(occ_r)
                                                   : dhmt_pkg::OCC_W'(0),
                      full_r,
                      succ_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_SLOTS))
    else $error("stored count above table size");

  a_count_only_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dhmt_pkg::S_PROBE) |=> (count_r == $past(count_r)))
    else $error("stored count changed outside probe walk");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == dhmt_pkg::S_CLEAR) || (state_r == dhmt_pkg::S_PROBE))
    else $error("table write outside clear or probe");

  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[0] && out_tdata_r[1]))
    else $error("success and table_full together");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_cnt_r <= CW'(TABLE_SLOTS))
    else $error("probe count past table size");

endmodule

FILE: test/dhmt_bag_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the bag and compares each result transfer.
module dhmt_bag_checker #(
  parameter int SLOTS = dhmt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [dhmt_pkg::ELEM_W-1:0] in_tdata,
  input  logic [dhmt_pkg::OPC_W-1:0]  in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [dhmt_pkg::OUT_W-1:0]  out_tdata,
  output int                          mismatches,
  output int                          outstanding
);

  typedef struct packed {
    logic                       success;
    logic                       table_full;
    logic [dhmt_pkg::OCC_W-1:0] occurrences;
    logic [dhmt_pkg::OCC_W-1:0] bag_size;
    logic                       bag_empty;
  } bag_result_t;

  logic [dhmt_pkg::ELEM_W-1:0] slot_val  [SLOTS];
  bit                          slot_used [SLOTS];
  int unsigned                 held;
  bag_result_t                 result_q[$];
  bag_result_t                 want;

  // Walk the double-hash probe sequence for one request and queue its result.
  task automatic model_request(input dhmt_pkg::op_t op,
                               input logic [dhmt_pkg::ELEM_W-1:0] elem);
    logic [dhmt_pkg::ELEM_W-1:0] mag;
    int unsigned                 n;
    int unsigned                 slot;
    int unsigned                 stride;
    int unsigned                 hits;
    bag_result_t                 r;
    n      = SLOTS;
    mag    = elem[dhmt_pkg::ELEM_W-1] ? (~elem + 1'b1) : elem;  // 0x80000000 stays as is
    slot   = mag % n;
    stride = 1 + mag % (n - 1);
    hits   = 0;
    r      = '0;
    case (op)
      dhmt_pkg::OP_INSERT: begin
        r.table_full = 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
          if (!slot_used[slot]) begin
            slot_used[slot] = 1'b1;
            slot_val[slot]  = elem;
            held++;
            r.success    = 1'b1;
            r.table_full = 1'b0;
            break;
          end
          slot = (slot + stride) % n;
        end
      end
      dhmt_pkg::OP_REMOVE: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (slot_used[slot] && slot_val[slot] == elem) begin
            slot_used[slot] = 1'b0;
            if (held > 0) held--;
            r.success = 1'b1;
            break;
          end
          slot = (slot + stride) % n;
        end
      end
      default: begin
        // search and count walk every probe, holes included
        for (int k = 0; k < SLOTS; k++) begin
          if (slot_used[slot] && slot_val[slot] == elem) hits++;
          slot = (slot + stride) % n;
        end
        r.success = (hits != 0);
        if (op == dhmt_pkg::OP_COUNT) r.occurrences = hits[dhmt_pkg::OCC_W-1:0];
      end
    endcase
    r.bag_size  = held[dhmt_pkg::OCC_W-1:0];
    r.bag_empty = (held == 0);
    result_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_val[i]  = '0;
      end
      held       = 0;
      mismatches = 0;
      result_q.delete();
    end else begin
      if (in_tvalid && in_tready) model_request(dhmt_pkg::op_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          $error("result transfer with no request outstanding");
        end else begin
          want = result_q.pop_front();
          check_field("success",     want.success,     out_tdata[0]);
          check_field("table_full",  want.table_full,  out_tdata[1]);
          check_field("occurrences", want.occurrences, out_tdata[11:2]);
          check_field("bag_size",    want.bag_size,    out_tdata[21:12]);
          check_field("bag_empty",   want.bag_empty,   out_tdata[22]);
          check_field("pad",         0,                out_tdata[23]);
        end
      end
    end
    outstanding = result_q.size();
  end

endmodule

FILE: test/tb_double_hash_multiset_table.sv
`timescale 1ns / 1ps

module tb_double_hash_multiset_table;

  localparam int SLOTS        = dhmt_pkg::TABLE_SLOTS_DEF;
  localparam int EW           = dhmt_pkg::ELEM_W;
  // A full probe walk plus hash and hand-off, stalls on both sides, many times over.
  // Also covers the clearing sweep after reset.
  localparam int STALL_LIMIT  = 8 * (SLOTS + 64);
  localparam int RANDOM_ITEMS = 520;
  localparam int HEAVY_COPIES = 24;
  localparam int HOT_COUNT    = 12;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [EW-1:0]              in_tdata   = '0;
  logic [dhmt_pkg::OPC_W-1:0] in_tuser   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [dhmt_pkg::OUT_W-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int quiet = 0;

  // Burst modes: while set, that side never idles.
  bit in_rush  = 1'b0;
  bit out_rush = 1'b0;

  // Small set of recurring values so inserts, removes and lookups collide.
  logic [EW-1:0] hot_values [HOT_COUNT];

  always #5 clk = ~clk;

  double_hash_multiset_table #(
    .TABLE_SLOTS(SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  dhmt_bag_checker #(
    .SLOTS(SLOTS)
  ) bag_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One request transfer. Called at a falling edge, returns at the falling edge
  // after the transfer. Valid stays high across back-to-back requests.
  task automatic issue(input dhmt_pkg::op_t op, input logic [EW-1:0] elem);
    int gap;
    gap = in_rush ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      // now and then let the block drain first so the gap lands on an idle block
      if ($urandom_range(0, 3) == 0) wait (outstanding == 0);
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = elem;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if ($urandom_range(0, 19) == 0) in_rush = !in_rush;
  endtask

  // Mostly recurring values, some fresh 32-bit patterns.
  function automatic logic [EW-1:0] pick_element();
    if ($urandom_range(0, 9) < 7) return hot_values[$urandom_range(0, HOT_COUNT - 1)];
    return $urandom;
  endfunction

  // Occasionally replace a recurring value, often with one that shares a probe
  // start or stride with another.
  task automatic stir_hot_values();
    int idx;
    int src;
    idx = $urandom_range(0, HOT_COUNT - 1);
    src = $urandom_range(0, HOT_COUNT - 1);
    case ($urandom_range(0, 4))
      0: hot_values[idx] = $urandom;
      1: hot_values[idx] = -hot_values[src];               // same magnitude
      2: hot_values[idx] = hot_values[src] + SLOTS;        // same first slot
      3: hot_values[idx] = hot_values[src] + (SLOTS - 1);  // same stride
      default: hot_values[idx] = $urandom_range(0, 4 * SLOTS);
    endcase
  endtask

  // Result side: after each result shows up, hold it off a drawn number of cycles.
  initial begin
    int hold;
    wait (rst_n);
    forever begin
      hold = out_rush ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        out_tready = 1'b0;
        do @(posedge clk); while (!out_tvalid);
        repeat (hold) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
      if ($urandom_range(0, 19) == 0) out_rush = !out_rush;
    end
  end

  initial begin
    int            roll;
    logic [EW-1:0] heavy;

    for (int i = 0; i < HOT_COUNT; i++) hot_values[i] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty bag, extreme values, shared probe starts, holes.
    issue(dhmt_pkg::OP_SEARCH, 32'd0);           // miss on empty bag
    issue(dhmt_pkg::OP_COUNT,  32'd0);
    issue(dhmt_pkg::OP_REMOVE, 32'd5);           // remove of an absent value
    issue(dhmt_pkg::OP_INSERT, 32'd0);
    issue(dhmt_pkg::OP_INSERT, 32'h7FFF_FFFF);
    issue(dhmt_pkg::OP_INSERT, 32'h8000_0001);   // most negative in range
    issue(dhmt_pkg::OP_INSERT, 32'h8000_0000);   // magnitude 2^31
    issue(dhmt_pkg::OP_INSERT, 32'hFFFF_FFFF);
    issue(dhmt_pkg::OP_INSERT, 32'd1);
    issue(dhmt_pkg::OP_INSERT, SLOTS);           // same first slot as zero
    issue(dhmt_pkg::OP_INSERT, -SLOTS);          // same magnitude, other value
    issue(dhmt_pkg::OP_INSERT, SLOTS);           // duplicate copy
    issue(dhmt_pkg::OP_COUNT,  SLOTS);
    issue(dhmt_pkg::OP_COUNT,  -SLOTS);
    issue(dhmt_pkg::OP_SEARCH, 32'h8000_0000);
    issue(dhmt_pkg::OP_SEARCH, 32'h7FFF_FFFE);
    issue(dhmt_pkg::OP_REMOVE, SLOTS);
    issue(dhmt_pkg::OP_COUNT,  SLOTS);           // one copy left past the hole
    issue(dhmt_pkg::OP_SEARCH, -SLOTS);
    issue(dhmt_pkg::OP_REMOVE, 32'h8000_0000);
    issue(dhmt_pkg::OP_SEARCH, 32'h8000_0000);
    issue(dhmt_pkg::OP_REMOVE, 32'h8000_0000);   // now absent
    issue(dhmt_pkg::OP_COUNT,  32'hFFFF_FFFF);
    issue(dhmt_pkg::OP_REMOVE, 32'd0);

    // Random mix, weighted toward inserts so the bag grows.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 7) == 0) stir_hot_values();
      roll = $urandom_range(0, 99);
      if (roll < 40)      issue(dhmt_pkg::OP_INSERT, pick_element());
      else if (roll < 62) issue(dhmt_pkg::OP_REMOVE, pick_element());
      else if (roll < 81) issue(dhmt_pkg::OP_SEARCH, pick_element());
      else                issue(dhmt_pkg::OP_COUNT,  pick_element());
    end

    // One value many times over, then counted, thinned and looked up.
    heavy = $urandom;
    for (int i = 0; i < HEAVY_COPIES; i++) issue(dhmt_pkg::OP_INSERT, heavy);
    issue(dhmt_pkg::OP_COUNT,  heavy);
    issue(dhmt_pkg::OP_REMOVE, heavy);
    issue(dhmt_pkg::OP_COUNT,  heavy);
    issue(dhmt_pkg::OP_SEARCH, heavy);
    in_tvalid = 1'b0;

    wait (outstanding == 0);
    repeat (SLOTS + 64) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
